>>> rtl/core/rotation_matrix_to_quaternion_macros.svh
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define RMQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rmq property failed");
// condition must never be seen at a clock edge out of reset
`define RMQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rmq forbidden condition seen");
`else
`define RMQ_ASSERT(lbl, clk, rst_n, prop)
`define RMQ_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/core/rmq_pkg.sv
package rmq_pkg;

    // element format and derived widths
    localparam int ELEM_WIDTH = 16;
    localparam int FRAC_BITS  = ELEM_WIDTH - 2;
    localparam int MAG_W      = ELEM_WIDTH + 1;
    localparam int RAD_W      = ELEM_WIDTH + 1;
    localparam int SUM_W      = ELEM_WIDTH + 2;
    localparam int ROOT_W     = ELEM_WIDTH;
    localparam int SQ_IN_W    = 2 * ELEM_WIDTH;
    localparam int REM_W      = ELEM_WIDTH + 3;
    localparam int NUM_W      = 2 * ELEM_WIDTH;
    localparam int DIV_W      = ELEM_WIDTH + 1;
    localparam int QUO_W      = ELEM_WIDTH - 1;

    // pipeline depth
    localparam int SQ_STAGES  = ELEM_WIDTH;
    localparam int DIV_STAGES = QUO_W;
    localparam int LATENCY    = 2 * ELEM_WIDTH + 3;

    // quaternion lanes
    localparam int NUM_LANES = 4;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_Z    = 2;
    localparam int LANE_W    = 3;

    typedef logic signed [ELEM_WIDTH-1:0] t_elem;
    typedef logic [1:0]                   t_pivot;

    // pivot codes
    localparam t_pivot PIVOT_ROW0  = 2'd0;
    localparam t_pivot PIVOT_ROW1  = 2'd1;
    localparam t_pivot PIVOT_ROW2  = 2'd2;
    localparam t_pivot PIVOT_TRACE = 2'd3;

    localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(1) << FRAC_BITS;
    localparam t_elem SAT_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam t_elem SAT_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    typedef struct packed {
        t_elem elem_0_0;
        t_elem elem_0_1;
        t_elem elem_0_2;
        t_elem elem_1_0;
        t_elem elem_1_1;
        t_elem elem_1_2;
        t_elem elem_2_0;
        t_elem elem_2_1;
        t_elem elem_2_2;
    } t_req;

    typedef struct packed {
        t_elem  quat_x;
        t_elem  quat_y;
        t_elem  quat_z;
        t_elem  quat_w;
        t_pivot pivot_used;
        logic   degenerate;
    } t_rsp;

    // side data carried along the square root
    typedef struct packed {
        logic [NUM_LANES-1:0][MAG_W-1:0] mag;
        logic [NUM_LANES-1:0]            neg;
        t_pivot                          pivot;
        logic                            degen;
    } t_ctx;

    // one divider stage, four lanes sharing one divisor
    typedef struct packed {
        logic [NUM_LANES-1:0][NUM_W-1:0] rem;
        logic [NUM_LANES-1:0][QUO_W-1:0] quo;
        logic [NUM_LANES-1:0]            ovf;
        logic [NUM_LANES-1:0]            neg;
        logic [DIV_W-1:0]                dvsr;
        logic [ROOT_W-1:0]               big;
        t_pivot                          pivot;
        logic                            degen;
    } t_div;

endpackage

>>> rtl/core/rotation_matrix_to_quaternion.sv
// rotation matrix (Q2.14) to unit quaternion (Q2.14), fully pipelined
// throughput: one matrix per cycle; busy stays low, set by one root bit and one
//   quotient bit per stage in the square root and divider chains
// reset: synchronous active low, clears all stage valid bits so no strobe follows
// the receiver cannot stall; every strobe is a new result
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rmq_pkg::t_req i_req,
    output logic          o_strobe,
    output rmq_pkg::t_rsp o_rsp
);
    import rmq_pkg::*;

    // input register
    logic r_a_vld;
    t_req r_a_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_req <= i_req;
    end

    // trace, pivot choice, radicand and lane numerators
    t_elem                     m00, m01, m02, m10, m11, m12, m20, m21, m22;
    t_elem                     mii, mjj, mkk;
    t_pivot                    piv;
    logic signed [SUM_W-1:0]   trace;
    logic signed [SUM_W-1:0]   rad_s;
    logic                      pos;
    logic signed [MAG_W-1:0]   dv [NUM_LANES];
    logic [RAD_W-1:0]          n_b_rad;
    t_ctx                      n_b_ctx;

    assign m00 = r_a_req.elem_0_0;
    assign m01 = r_a_req.elem_0_1;
    assign m02 = r_a_req.elem_0_2;
    assign m10 = r_a_req.elem_1_0;
    assign m11 = r_a_req.elem_1_1;
    assign m12 = r_a_req.elem_1_2;
    assign m20 = r_a_req.elem_2_0;
    assign m21 = r_a_req.elem_2_1;
    assign m22 = r_a_req.elem_2_2;

    assign trace = SUM_W'(m00) + SUM_W'(m11) + SUM_W'(m22);
    assign pos   = !trace[SUM_W-1] && (trace != '0);

    always_comb begin
        piv = PIVOT_ROW0;
        mii = m00;
        if (m11 > m00) begin
            piv = PIVOT_ROW1;
            mii = m11;
        end
        if (m22 > mii) begin
            piv = PIVOT_ROW2;
            mii = m22;
        end
        for (int c = 0; c < NUM_LANES; c++) begin
            dv[c] = '0;
        end
        mjj = m11;
        mkk = m22;
        if (pos) begin
            dv[LANE_X] = MAG_W'(m12) - MAG_W'(m21);
            dv[LANE_Y] = MAG_W'(m20) - MAG_W'(m02);
            dv[LANE_Z] = MAG_W'(m01) - MAG_W'(m10);
        end else begin
            case (piv)
                PIVOT_ROW0: begin
                    mjj = m11;
                    mkk = m22;
                    dv[LANE_W] = MAG_W'(m12) - MAG_W'(m21);
                    dv[LANE_Y] = MAG_W'(m01) + MAG_W'(m10);
                    dv[LANE_Z] = MAG_W'(m02) + MAG_W'(m20);
                end
                PIVOT_ROW1: begin
                    mjj = m22;
                    mkk = m00;
                    dv[LANE_W] = MAG_W'(m20) - MAG_W'(m02);
                    dv[LANE_Z] = MAG_W'(m12) + MAG_W'(m21);
                    dv[LANE_X] = MAG_W'(m10) + MAG_W'(m01);
                end
                default: begin
                    mjj = m00;
                    mkk = m11;
                    dv[LANE_W] = MAG_W'(m01) - MAG_W'(m10);
                    dv[LANE_X] = MAG_W'(m20) + MAG_W'(m02);
                    dv[LANE_Y] = MAG_W'(m21) + MAG_W'(m12);
                end
            endcase
        end
        if (pos) begin
            rad_s = trace + ONE_Q;
        end else begin
            rad_s = SUM_W'(mii) - (SUM_W'(mjj) + SUM_W'(mkk)) + ONE_Q;
        end
        n_b_ctx.pivot = pos ? PIVOT_TRACE : piv;
        n_b_ctx.degen = !pos && (rad_s[SUM_W-1] || (rad_s == '0));
        n_b_rad       = n_b_ctx.degen ? RAD_W'(1) : rad_s[RAD_W-1:0];
        for (int c = 0; c < NUM_LANES; c++) begin
            n_b_ctx.neg[c] = dv[c][MAG_W-1];
            n_b_ctx.mag[c] = dv[c][MAG_W-1] ? MAG_W'(-dv[c]) : MAG_W'(dv[c]);
        end
    end

    logic             r_b_vld;
    logic [RAD_W-1:0] r_b_rad;
    t_ctx             r_b_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_rad <= n_b_rad;
        r_b_ctx <= n_b_ctx;
    end

    // pipelined square root
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    t_ctx              sq_ctx;

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_rad   (r_b_rad),
        .i_ctx   (r_b_ctx),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_ctx   (sq_ctx)
    );

    // divider setup: rounded numerators, divisor 2s, overflow check, large lane
    t_div            n_c;
    logic [ROOT_W:0] s_inc;

    always_comb begin
        s_inc      = {1'b0, sq_root} + 1'b1;
        n_c.dvsr   = {sq_root, 1'b0};
        n_c.big    = s_inc[ROOT_W:1];
        n_c.pivot  = sq_ctx.pivot;
        n_c.degen  = sq_ctx.degen;
        n_c.neg    = sq_ctx.neg;
        for (int c = 0; c < NUM_LANES; c++) begin
            n_c.rem[c] = NUM_W'({sq_ctx.mag[c], {FRAC_BITS{1'b0}}}) + NUM_W'(sq_root);
            n_c.quo[c] = '0;
            n_c.ovf[c] = n_c.rem[c] >= {n_c.dvsr, {QUO_W{1'b0}}};
        end
    end

    logic r_c_vld;
    t_div r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    // restoring divider, one quotient bit per stage
    logic s_dv_vld [DIV_STAGES+1];
    t_div s_dv     [DIV_STAGES+1];
    logic r_dv_vld [DIV_STAGES];
    t_div r_dv     [DIV_STAGES];
    t_div n_dv     [DIV_STAGES];

    assign s_dv_vld[0] = r_c_vld;
    assign s_dv[0]     = r_c;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_dlink
        assign s_dv_vld[g+1] = r_dv_vld[g];
        assign s_dv[g+1]     = r_dv[g];
    end

    always_comb begin
        logic [NUM_W-1:0] shd;
        shd = '0;
        for (int j = 0; j < DIV_STAGES; j++) begin
            n_dv[j] = s_dv[j];
            shd     = NUM_W'(s_dv[j].dvsr) << (QUO_W - 1 - j);
            for (int c = 0; c < NUM_LANES; c++) begin
                if (s_dv[j].rem[c] >= shd) begin
                    n_dv[j].rem[c]               = s_dv[j].rem[c] - shd;
                    n_dv[j].quo[c][QUO_W-1-j]    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else begin
                r_dv_vld[j] <= s_dv_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            r_dv[j] <= n_dv[j];
        end
    end

    // sign, saturation and lane assembly
    t_div   dv_out;
    t_pivot big_lane;
    t_elem  lane_val [NUM_LANES];
    t_elem  qmag;
    t_rsp   n_rsp;

    assign dv_out   = s_dv[DIV_STAGES];
    assign big_lane = (dv_out.pivot == PIVOT_TRACE) ? t_pivot'(LANE_W) : dv_out.pivot;

    always_comb begin
        qmag = '0;
        for (int c = 0; c < NUM_LANES; c++) begin
            qmag = {1'b0, dv_out.quo[c]};
            if (t_pivot'(c) == big_lane) begin
                lane_val[c] = dv_out.big;
            end else if (dv_out.ovf[c]) begin
                lane_val[c] = dv_out.neg[c] ? SAT_MIN : SAT_MAX;
            end else begin
                lane_val[c] = dv_out.neg[c] ? -qmag : qmag;
            end
        end
        n_rsp.quat_x     = lane_val[LANE_X];
        n_rsp.quat_y     = lane_val[LANE_Y];
        n_rsp.quat_z     = lane_val[LANE_Z];
        n_rsp.quat_w     = lane_val[LANE_W];
        n_rsp.pivot_used = dv_out.pivot;
        n_rsp.degenerate = dv_out.degen;
    end

    logic r_out_vld;
    t_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= s_dv_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign busy     = 1'b0;
    assign o_strobe = r_out_vld;
    assign o_rsp    = r_rsp;

    // checks
    `RMQ_ASSERT(a_req_to_strobe, i_clk, i_rst_n, start |-> ##LATENCY o_strobe)
    `RMQ_ASSERT(a_strobe_has_req, i_clk, i_rst_n, o_strobe |-> $past(start, LATENCY))
    `RMQ_ASSERT_NEVER(a_degen_trace, i_clk, i_rst_n, o_strobe && o_rsp.degenerate && (o_rsp.pivot_used == PIVOT_TRACE))
    `RMQ_ASSERT(a_degen_clamp, i_clk, i_rst_n, (r_b_vld && r_b_ctx.degen) |-> (r_b_rad == RAD_W'(1)))
    `RMQ_ASSERT(a_sqrt_depth, i_clk, i_rst_n, r_c_vld |-> $past(r_b_vld, SQ_STAGES + 1))

endmodule

>>> rtl/core/rmq_sqrt.sv
module rmq_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [rmq_pkg::RAD_W-1:0]  i_rad,
    input  rmq_pkg::t_ctx        i_ctx,
    output logic                 o_vld,
    output logic [rmq_pkg::ROOT_W-1:0] o_root,
    output rmq_pkg::t_ctx        o_ctx
);
    import rmq_pkg::*;

    // stage inputs: index 0 is the entry, index k+1 is register stage k
    logic                s_vld  [SQ_STAGES+1];
    logic [REM_W-1:0]    s_rem  [SQ_STAGES+1];
    logic [ROOT_W-1:0]   s_root [SQ_STAGES+1];
    logic [SQ_IN_W-1:0]  s_bits [SQ_STAGES+1];
    t_ctx                s_ctx  [SQ_STAGES+1];

    logic                r_vld  [SQ_STAGES];
    logic [REM_W-1:0]    r_rem  [SQ_STAGES];
    logic [ROOT_W-1:0]   r_root [SQ_STAGES];
    logic [SQ_IN_W-1:0]  r_bits [SQ_STAGES];
    t_ctx                r_ctx  [SQ_STAGES];

    logic                n_vld  [SQ_STAGES];
    logic [REM_W-1:0]    n_rem  [SQ_STAGES];
    logic [ROOT_W-1:0]   n_root [SQ_STAGES];
    logic [SQ_IN_W-1:0]  n_bits [SQ_STAGES];
    t_ctx                n_ctx  [SQ_STAGES];

    // entry: radicand scaled by 2^F, left aligned on an even boundary
    assign s_vld[0]  = i_vld;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_bits[0] = {1'b0, i_rad, {FRAC_BITS{1'b0}}};
    assign s_ctx[0]  = i_ctx;

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_link
        assign s_vld[g+1]  = r_vld[g];
        assign s_rem[g+1]  = r_rem[g];
        assign s_root[g+1] = r_root[g];
        assign s_bits[g+1] = r_bits[g];
        assign s_ctx[g+1]  = r_ctx[g];
    end

    // one root bit per stage
    always_comb begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = '0;
        trial  = '0;
        for (int k = 0; k < SQ_STAGES; k++) begin
            rem_sh    = {s_rem[k][REM_W-3:0], s_bits[k][SQ_IN_W-1 -: 2]};
            trial     = REM_W'({s_root[k], 2'b01});
            n_vld[k]  = s_vld[k];
            n_ctx[k]  = s_ctx[k];
            n_bits[k] = {s_bits[k][SQ_IN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem[k]  = rem_sh - trial;
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = rem_sh;
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_STAGES; k++) begin
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
            r_bits[k] <= n_bits[k];
            r_ctx[k]  <= n_ctx[k];
        end
    end

    assign o_vld  = s_vld[SQ_STAGES];
    assign o_root = s_root[SQ_STAGES];
    assign o_ctx  = s_ctx[SQ_STAGES];

endmodule

>>> verif/rotation_matrix_to_quaternion_test.sv
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_test;
    import rmq_pkg::*;

    localparam int F         = FRAC_BITS;
    localparam int MAX_CYC   = 200000;
    localparam int N_RANDOM  = 450;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_strobe;
    t_rsp  o_rsp;

    t_req  pending_reqs[$];
    t_rsp  expected_quats[$];
    int    mismatches;
    int    cycles;
    bit    stim_done;
    bit    calm;

    rotation_matrix_to_quaternion dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    // clock, low first so no rising edge lands at time zero
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // integer square root
    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // d * 2^F / 2s rounded half away from zero
    function automatic longint half_ratio(longint d, longint unsigned s);
        longint unsigned mag;
        longint q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = longint'(((mag << F) + s) / (2 * s));
        return (d < 0) ? -q : q;
    endfunction

    function automatic t_elem clip(longint v);
        if (v > longint'(SAT_MAX)) return SAT_MAX;
        if (v < longint'(SAT_MIN)) return SAT_MIN;
        return t_elem'(v);
    endfunction

    // quaternion from matrix
    function automatic t_rsp matrix_to_quat(t_req r);
        longint m[3][3];
        longint q[4];
        longint tr;
        longint rad;
        longint unsigned s;
        int i;
        int j;
        int k;
        t_rsp o;
        m[0][0] = r.elem_0_0; m[0][1] = r.elem_0_1; m[0][2] = r.elem_0_2;
        m[1][0] = r.elem_1_0; m[1][1] = r.elem_1_1; m[1][2] = r.elem_1_2;
        m[2][0] = r.elem_2_0; m[2][1] = r.elem_2_1; m[2][2] = r.elem_2_2;
        o.degenerate = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            rad = tr + (64'sd1 << F);
            s = int_root(longint'(rad) << F);
            q[LANE_W] = longint'((s + 1) >> 1);
            q[LANE_X] = half_ratio(m[1][2] - m[2][1], s);
            q[LANE_Y] = half_ratio(m[2][0] - m[0][2], s);
            q[LANE_Z] = half_ratio(m[0][1] - m[1][0], s);
            o.pivot_used = PIVOT_TRACE;
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            rad = (m[i][i] - (m[j][j] + m[k][k])) + (64'sd1 << F);
            if (rad <= 0) begin
                rad = 1;
                o.degenerate = 1'b1;
            end
            s = int_root(longint'(rad) << F);
            q[i] = longint'((s + 1) >> 1);
            q[LANE_W] = half_ratio(m[j][k] - m[k][j], s);
            q[j] = half_ratio(m[i][j] + m[j][i], s);
            q[k] = half_ratio(m[i][k] + m[k][i], s);
            o.pivot_used = t_pivot'(i);
        end
        o.quat_x = clip(q[LANE_X]);
        o.quat_y = clip(q[LANE_Y]);
        o.quat_z = clip(q[LANE_Z]);
        o.quat_w = clip(q[LANE_W]);
        return o;
    endfunction

    function automatic t_elem rand_elem();
        return t_elem'($urandom_range(0, 65535));
    endfunction

    // near-rotation element: value in about [-1, 1] q2.14
    function automatic t_elem unit_elem();
        return t_elem'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic t_req diag_req(t_elem a, t_elem b, t_elem c);
        t_req r;
        r = '0;
        r.elem_0_0 = a;
        r.elem_1_1 = b;
        r.elem_2_2 = c;
        return r;
    endfunction

    // stimulus
    initial begin
        t_req r;
        stim_done = 1'b0;
        pending_reqs.push_back(diag_req(16'sd16384, 16'sd16384, 16'sd16384));
        pending_reqs.push_back(diag_req(16'sd16384, -16'sd16384, -16'sd16384));
        pending_reqs.push_back(diag_req(-16'sd16384, 16'sd16384, -16'sd16384));
        pending_reqs.push_back(diag_req(-16'sd16384, -16'sd16384, 16'sd16384));
        pending_reqs.push_back(diag_req(16'sd0, 16'sd0, 16'sd0));
        pending_reqs.push_back(diag_req(16'sd100, 16'sd100, -16'sd200));
        pending_reqs.push_back(diag_req(-16'sd5, -16'sd5, -16'sd5));
        pending_reqs.push_back(diag_req(SAT_MIN, SAT_MIN, SAT_MIN));
        pending_reqs.push_back(diag_req(SAT_MAX, SAT_MAX, SAT_MAX));
        pending_reqs.push_back(diag_req(SAT_MAX, SAT_MIN, SAT_MIN));
        pending_reqs.push_back(diag_req(-16'sd16384, SAT_MAX, SAT_MIN));
        pending_reqs.push_back(diag_req(SAT_MIN, SAT_MIN, SAT_MAX));
        pending_reqs.push_back(diag_req(16'sd1, 16'sd0, -16'sd1));
        // large off-diagonals on every path, forcing saturation
        for (int p = 0; p < 4; p++) begin
            r = '{default: SAT_MAX};
            r.elem_1_0 = SAT_MIN; r.elem_2_1 = SAT_MIN; r.elem_0_2 = SAT_MIN;
            r.elem_0_0 = (p == 0) ? SAT_MIN : SAT_MIN;
            r.elem_1_1 = SAT_MIN;
            r.elem_2_2 = SAT_MIN;
            if (p < 3) begin
                if (p == 0) r.elem_0_0 = 16'sd0;
                if (p == 1) r.elem_1_1 = 16'sd0;
                if (p == 2) r.elem_2_2 = 16'sd0;
            end else begin
                r.elem_0_0 = 16'sd16384; r.elem_1_1 = -16'sd16000;
                r.elem_2_2 = -16'sd300;
            end
            pending_reqs.push_back(r);
        end
        r = '{default: SAT_MIN};
        pending_reqs.push_back(r);
        r = '{default: SAT_MAX};
        pending_reqs.push_back(r);
        // random: mostly near-rotation content, some full-range noise
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 99) < 70) begin
                r.elem_0_0 = unit_elem(); r.elem_0_1 = unit_elem();
                r.elem_0_2 = unit_elem(); r.elem_1_0 = unit_elem();
                r.elem_1_1 = unit_elem(); r.elem_1_2 = unit_elem();
                r.elem_2_0 = unit_elem(); r.elem_2_1 = unit_elem();
                r.elem_2_2 = unit_elem();
                // occasional tie on the diagonal
                if ($urandom_range(0, 9) == 0) r.elem_1_1 = r.elem_0_0;
                if ($urandom_range(0, 9) == 0) r.elem_2_2 = r.elem_1_1;
            end else begin
                r.elem_0_0 = rand_elem(); r.elem_0_1 = rand_elem();
                r.elem_0_2 = rand_elem(); r.elem_1_0 = rand_elem();
                r.elem_1_1 = rand_elem(); r.elem_1_2 = rand_elem();
                r.elem_2_0 = rand_elem(); r.elem_2_1 = rand_elem();
                r.elem_2_2 = rand_elem();
            end
            pending_reqs.push_back(r);
        end
        stim_done = 1'b1;
    end

    // reset
    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: one request per accepting edge, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
            calm  <= 1'b0;
        end else begin
            if (!start || !busy) begin
                if (start) expected_quats.push_back(matrix_to_quat(i_req));
                if ($urandom_range(0, 199) == 0) calm <= !calm;
                if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
                    i_req <= pending_reqs.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp exp_q;
        if (i_rst_n && o_strobe) begin
            if (expected_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_rsp);
            end else begin
                exp_q = expected_quats.pop_front();
                if (o_rsp !== exp_q) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp x=%h y=%h z=%h w=%h p=%0d d=%b",
                                  " got x=%h y=%h z=%h w=%h p=%0d d=%b"},
                            exp_q.quat_x, exp_q.quat_y, exp_q.quat_z, exp_q.quat_w,
                            exp_q.pivot_used, exp_q.degenerate,
                            o_rsp.quat_x, o_rsp.quat_y, o_rsp.quat_z, o_rsp.quat_w,
                            o_rsp.pivot_used, o_rsp.degenerate);
                end
            end
        end
    end

    // end of run
    initial begin
        mismatches = 0;
        cycles = 0;
        start = 1'b0;
        i_req = '0;
        while (!(stim_done && pending_reqs.size() == 0 && !start
                 && expected_quats.size() == 0) && cycles < MAX_CYC) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= MAX_CYC) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            repeat (LATENCY + 10) @(posedge i_clk);
            if (mismatches == 0) begin
                $display("== PASS ==");
            end else begin
                $display("== FAIL ==");
            end
            $finish;
        end
    end

endmodule
